// ===== src/lpi_pkg.sv =====
// Shared types and constants for the line pair intersection block.
// Used by lpi_div and line_pair_intersection_top; no dependencies.
package lpi_pkg;

  // Q16.16 word and fraction widths
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int TOL_W     = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd6554;  // 0.1 in Q16.16

  // differences of two words need one more bit
  localparam int NUM_W   = DATA_W + 1;
  // numerator magnitude after the fraction shift
  localparam int SHIFT_W = NUM_W + FRAC_BITS;
  // product shifted down by the fraction, plus intercept
  localparam int SUM_W   = 2 * DATA_W - FRAC_BITS + 1;

  localparam int S_TDATA_W = 6 * DATA_W;
  localparam int M_FIELD_W = 2 * DATA_W + 1;
  localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // which way a line pair is solved
  localparam logic [1:0] KIND_BOTH_VERT = 2'd0;
  localparam logic [1:0] KIND_ONE_VERT  = 2'd1;
  localparam logic [1:0] KIND_PARALLEL  = 2'd2;
  localparam logic [1:0] KIND_DIVIDE    = 2'd3;

  // per-step state of the restoring divider
  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [NUM_W-1:0]  dmag;
    logic [DATA_W-1:0] nq;    // numerator bits shift out, quotient bits shift in
  } lpi_div_t;

  // request data riding alongside the divider
  typedef struct packed {
    logic                     given;
    logic                     meet_np;   // meet flag for the no-point cases
    logic                     divide;
    logic                     neg;
    logic                     over;      // quotient magnitude >= 2^DATA_W
    logic signed [DATA_W-1:0] xv;
    logic signed [DATA_W-1:0] m;
    logic signed [DATA_W-1:0] c;
  } lpi_side_t;

  // one result
  typedef struct packed {
    logic                     sat;
    logic                     given;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] x;
    logic                     meet;
  } lpi_res_t;

endpackage

// ===== src/line_pair_intersection_top.sv =====
// Line pair intersection: top level, stream ports, pipeline and output skid.
// Depends on lpi_pkg and lpi_div.
//
// Each request carries two lines, each either y = m*x + c or vertical at
// x = xpos, and yields one result: whether the lines meet and, when they
// meet in one point, that point in signed Q16.16 with a saturation flag.
// Two vertical lines meet when their x positions differ by less than the
// tolerance register (reset 0.1); equal slopes meet only on equal
// intercepts; neither case gives a point. The pipeline takes one request
// per cycle while s_tready is high. The request passes 39 register stages,
// the first loaded at the accepting edge: three stages of setup, a 32-stage
// restoring divider (one quotient bit per stage), one stage of clamping,
// one 32x32 multiply stage, one add-and-clamp stage and the output register.
// A two-entry output (register plus skid) lets the pipeline keep accepting
// while a result waits; s_tready drops only once the skid entry is full,
// and the whole pipeline then holds. The tolerance register is written
// through cfg_valid/cfg_data, which are always ready; write it only while
// no request is in flight.
module line_pair_intersection_top import lpi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TOL_W-1:0]     cfg_data,    // vertical_tolerance
  // request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // slope_first, icept_first, xpos_first, slope_second, icept_second, xpos_second
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [1:0]           s_tuser,     // upright_first, upright_second
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,     // lines_meet, meet_x, meet_y, zero pad
  output logic [1:0]           m_tuser      // point_given, saturated
);

  logic [TOL_W-1:0] tolerance;
  logic             en;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_valid) begin
      tolerance <= cfg_data;
    end
  end

  // ---------------------------------------------------------- input unpack
  logic signed [DATA_W-1:0] m1, c1, x1, m2, c2, x2;
  logic                     v1, v2;

  assign m1 = s_tdata[0*DATA_W +: DATA_W];
  assign c1 = s_tdata[1*DATA_W +: DATA_W];
  assign x1 = s_tdata[2*DATA_W +: DATA_W];
  assign m2 = s_tdata[3*DATA_W +: DATA_W];
  assign c2 = s_tdata[4*DATA_W +: DATA_W];
  assign x2 = s_tdata[5*DATA_W +: DATA_W];
  assign v1 = s_tuser[0];
  assign v2 = s_tuser[1];

  // whole pipeline advances unless the skid entry is occupied
  assign s_tready = en;

  // --------------------------------------------- stage 1: classify, differ
  logic                     s1_valid;
  logic [1:0]               s1_kind;
  logic signed [NUM_W-1:0]  s1_num, s1_den, s1_dx;
  logic                     s1_icept_eq;
  logic signed [DATA_W-1:0] s1_xv, s1_m, s1_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (v1 && v2) begin
        s1_kind <= KIND_BOTH_VERT;
      end else if (v1 || v2) begin
        s1_kind <= KIND_ONE_VERT;
      end else if (m1 == m2) begin
        s1_kind <= KIND_PARALLEL;
      end else begin
        s1_kind <= KIND_DIVIDE;
      end
      s1_num      <= NUM_W'(c2) - NUM_W'(c1);
      s1_den      <= NUM_W'(m1) - NUM_W'(m2);
      s1_dx       <= NUM_W'(x1) - NUM_W'(x2);
      s1_icept_eq <= (c1 == c2);
      // y always comes from the sloped line; x from the vertical one
      s1_xv <= v1 ? x1 : x2;
      s1_m  <= v1 ? m2 : m1;
      s1_c  <= v1 ? c2 : c1;
    end
  end

  // ------------------------------------ stage 2: magnitudes, vertical test
  logic                     s2_valid;
  logic [1:0]               s2_kind;
  logic [NUM_W-1:0]         s2_nmag, s2_dmag;
  logic                     s2_neg, s2_meet_np;
  logic signed [DATA_W-1:0] s2_xv, s2_m, s2_c;
  logic signed [NUM_W-1:0]  tol_s;
  logic                     vert_meet;

  assign tol_s     = $signed({{(NUM_W-TOL_W){1'b0}}, tolerance});
  assign vert_meet = (s1_dx < tol_s) && (s1_dx > -tol_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind <= s1_kind;
      s2_nmag <= s1_num[NUM_W-1] ? NUM_W'(-s1_num) : NUM_W'(s1_num);
      s2_dmag <= s1_den[NUM_W-1] ? NUM_W'(-s1_den) : NUM_W'(s1_den);
      s2_neg  <= s1_num[NUM_W-1] ^ s1_den[NUM_W-1];
      case (s1_kind)
        KIND_BOTH_VERT: s2_meet_np <= vert_meet;
        KIND_PARALLEL:  s2_meet_np <= s1_icept_eq;
        default:        s2_meet_np <= 1'b0;
      endcase
      s2_xv <= s1_xv;
      s2_m  <= s1_m;
      s2_c  <= s1_c;
    end
  end

  // ------------------------------- stage 3: divider setup, overflow check
  // Quotient is (nmag << FRAC_BITS) / dmag. Its upper bits are nonzero
  // exactly when the bits above DATA_W already reach dmag; otherwise only the
  // low DATA_W quotient bits are needed and the remainder starts below dmag.
  logic [SHIFT_W-1:0] nshift;
  logic [NUM_W-1:0]   rem0;
  logic               s3_valid;
  lpi_div_t           s3_div;
  lpi_side_t          s3_side;

  assign nshift = {s2_nmag, {FRAC_BITS{1'b0}}};
  assign rem0   = NUM_W'(nshift[SHIFT_W-1:DATA_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_div.rem      <= rem0;
      s3_div.dmag     <= s2_dmag;
      s3_div.nq       <= nshift[DATA_W-1:0];
      s3_side.given   <= (s2_kind == KIND_ONE_VERT) || (s2_kind == KIND_DIVIDE);
      s3_side.divide  <= (s2_kind == KIND_DIVIDE);
      s3_side.meet_np <= s2_meet_np;
      s3_side.neg     <= s2_neg;
      s3_side.over    <= (rem0 >= s2_dmag);
      s3_side.xv      <= s2_xv;
      s3_side.m       <= s2_m;
      s3_side.c       <= s2_c;
    end
  end

  // ---------------------------------------------------------------- divide
  logic              dv_valid;
  logic [DATA_W-1:0] dv_quot;
  lpi_side_t         dv_side;

  lpi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .in_div    (s3_div),
    .in_side   (s3_side),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // ------------------------------------------ stage 4: sign and clamp of x
  logic                     s4_valid, s4_sat, s4_given, s4_meet_np;
  logic signed [DATA_W-1:0] s4_x, s4_m, s4_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_given   <= dv_side.given;
      s4_meet_np <= dv_side.meet_np;
      s4_m       <= dv_side.m;
      s4_c       <= dv_side.c;
      if (!dv_side.divide) begin
        s4_x   <= dv_side.xv;
        s4_sat <= 1'b0;
      end else if (!dv_side.neg) begin
        if (dv_side.over || dv_quot[DATA_W-1]) begin
          s4_x   <= Q_MAX;
          s4_sat <= 1'b1;
        end else begin
          s4_x   <= $signed(dv_quot);
          s4_sat <= 1'b0;
        end
      end else begin
        // magnitude 2^(DATA_W-1) still fits as the most negative value
        if (dv_side.over || (dv_quot[DATA_W-1] && |dv_quot[DATA_W-2:0])) begin
          s4_x   <= Q_MIN;
          s4_sat <= 1'b1;
        end else begin
          s4_x   <= $signed(-dv_quot);
          s4_sat <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------ stage 5: m * x product
  logic                       s5_valid, s5_sat, s5_given, s5_meet_np;
  logic signed [DATA_W-1:0]   s5_x, s5_c;
  logic signed [2*DATA_W-1:0] s5_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_prod    <= (2*DATA_W)'(s4_m) * (2*DATA_W)'(s4_x);
      s5_x       <= s4_x;
      s5_c       <= s4_c;
      s5_sat     <= s4_sat;
      s5_given   <= s4_given;
      s5_meet_np <= s4_meet_np;
    end
  end

  // ---------------------------------- stage 6: floor shift, add c, clamp y
  logic signed [SUM_W-1:0]  y_sum;
  logic                     y_fits;
  logic signed [DATA_W-1:0] y_val;
  logic                     fin_valid;
  lpi_res_t                 fin_res;

  // dropping the low bits of a two's complement product is a floor divide
  assign y_sum  = SUM_W'($signed(s5_prod[2*DATA_W-1:FRAC_BITS])) + SUM_W'(s5_c);
  assign y_fits = (y_sum[SUM_W-1:DATA_W-1] == '0) || (y_sum[SUM_W-1:DATA_W-1] == '1);
  assign y_val  = y_fits ? y_sum[DATA_W-1:0] : (y_sum[SUM_W-1] ? Q_MIN : Q_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_res.meet  <= s5_given | s5_meet_np;
      fin_res.given <= s5_given;
      fin_res.x     <= s5_given ? s5_x : '0;
      fin_res.y     <= s5_given ? y_val : '0;
      fin_res.sat   <= s5_given & (s5_sat | ~y_fits);
    end
  end

  // ------------------------------------------- output register and skid
  logic     skid_valid;
  lpi_res_t skid_res;
  lpi_res_t out_res;
  logic     out_free;

  assign en       = ~skid_valid;
  assign out_free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= fin_valid;
      end
    end else if (fin_valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : fin_res;
    end else if (en) begin
      skid_res <= fin_res;
    end
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, out_res.y, out_res.x, out_res.meet};
  assign m_tuser = {out_res.sat, out_res.given};

  // ------------------------------------------------------------ assertions
  // skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid holds a result while the output register is empty");

  // a finished result arriving at a stalled output must land in the skid
  a_skid_catches: assert property (@(posedge clk) disable iff (rst)
    (en && fin_valid && m_tvalid && !m_tready) |=> skid_valid)
    else $error("result dropped at a stalled output");

  // a given point always means the lines meet
  a_point_meets: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.given) |-> out_res.meet)
    else $error("point given without lines_meet");

  // no point: coordinates and saturation are zero
  a_no_point_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_res.given) |-> (out_res.x == '0 && out_res.y == '0 && !out_res.sat))
    else $error("nonzero point fields with no point given");

endmodule

// ===== src/lpi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on lpi_pkg.
module lpi_div import lpi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  lpi_div_t          in_div,
  input  lpi_side_t         in_side,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_quot,
  output lpi_side_t         out_side
);

  localparam int STEPS = DATA_W;

  logic [STEPS-1:0] vld;
  lpi_div_t         st  [STEPS];
  lpi_side_t        sd  [STEPS];
  lpi_div_t         nxt [STEPS];

  always_comb begin
    lpi_div_t        cur;
    logic [NUM_W:0]  trial;
    logic [NUM_W:0]  diff;
    logic            fits;
    for (int k = 0; k < STEPS; k++) begin
      cur   = (k == 0) ? in_div : st[(k == 0) ? 0 : k - 1];
      trial = {cur.rem, cur.nq[DATA_W-1]};
      diff  = trial - {1'b0, cur.dmag};
      fits  = trial >= {1'b0, cur.dmag};
      nxt[k].rem  = fits ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
      nxt[k].dmag = cur.dmag;
      nxt[k].nq   = {cur.nq[DATA_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STEPS; k++) begin
        st[k] <= nxt[k];
        sd[k] <= (k == 0) ? in_side : sd[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign out_quot  = st[STEPS-1].nq;
  assign out_side  = sd[STEPS-1];

endmodule
